// ===== hw/rtl/arpnf_pkg.sv =====
// ----------------------------------------------------------------------------
// arpnf_pkg
// Shared types, codes and helpers for the ARP responder / neighbor forwarder.
// ----------------------------------------------------------------------------
package arpnf_pkg;

  localparam int unsigned NEIGHBOR_ENTRIES = 1024;
  localparam int unsigned IDX_W            = $clog2(NEIGHBOR_ENTRIES);

  // packet kind codes
  localparam logic [1:0] OP_ARP  = 2'd0;
  localparam logic [1:0] OP_IPV4 = 2'd1;

  // result action codes
  localparam logic [1:0] ACT_DROP    = 2'd0;
  localparam logic [1:0] ACT_REPLY   = 2'd1;
  localparam logic [1:0] ACT_FORWARD = 2'd2;

  localparam logic [15:0] ARP_REQUEST = 16'd1;

  // config register indexes
  localparam logic [1:0] CFG_VALID = 2'd0;
  localparam logic [1:0] CFG_PORT  = 2'd1;
  localparam logic [1:0] CFG_IP    = 2'd2;
  localparam logic [1:0] CFG_MAC   = 2'd3;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  port;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic probe_next;
    logic resolve;
    logic load_out;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic is_other;
    logic hit;
    logic empty;
    logic last_probe;
    logic clr_last;
    logic out_free;
  } status_t;

  // xor-fold of an IPv4 address into a table index
  function automatic logic [IDX_W-1:0] hash_ip(logic [31:0] ip);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < 32; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ ip[i];
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/arpnf_ram.sv =====
// ----------------------------------------------------------------------------
// arpnf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arpnf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/arpnf_ctrl.sv =====
// ----------------------------------------------------------------------------
// arpnf_ctrl
// Sequencer: table clear, probe loop, resolve and result hand-off.
// ----------------------------------------------------------------------------
module arpnf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  arpnf_pkg::status_t status_i,
  output arpnf_pkg::cmd_t    cmd_o,
  output logic               in_stall_o
);

  arpnf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpnf_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      arpnf_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = arpnf_pkg::ST_IDLE;
      end
      arpnf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.is_other ? arpnf_pkg::ST_DONE : arpnf_pkg::ST_READ;
        end
      end
      arpnf_pkg::ST_READ: state_d = arpnf_pkg::ST_CHECK;
      arpnf_pkg::ST_CHECK: begin
        if (status_i.hit || status_i.empty || status_i.last_probe) begin
          state_d = arpnf_pkg::ST_DONE;
        end else begin
          state_d = arpnf_pkg::ST_READ;
        end
      end
      arpnf_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = arpnf_pkg::ST_IDLE;
      end
      default: state_d = arpnf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      arpnf_pkg::ST_CLEAR: cmd_o.clear_step = 1'b1;
      arpnf_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      arpnf_pkg::ST_READ: ;
      arpnf_pkg::ST_CHECK: begin
        if (status_i.hit || status_i.empty || status_i.last_probe) begin
          cmd_o.resolve = 1'b1;
        end else begin
          cmd_o.probe_next = 1'b1;
        end
      end
      arpnf_pkg::ST_DONE: cmd_o.load_out = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/arpnf_datapath.sv =====
// ----------------------------------------------------------------------------
// arpnf_datapath
// Config registers, header capture, hashed probe address, neighbor RAM,
// result build and output register.
// ----------------------------------------------------------------------------
module arpnf_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arpnf_pkg::cmd_t    cmd_i,
  output arpnf_pkg::status_t status_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [47:0]        cfg_data_i,
  input  logic [1:0]         in_op_i,
  input  logic [7:0]         in_port_i,
  input  logic [47:0]        in_src_mac_i,
  input  logic [15:0]        in_arp_opcode_i,
  input  logic [31:0]        in_arp_sender_ip_i,
  input  logic [31:0]        in_arp_target_ip_i,
  input  logic [31:0]        in_ip_dest_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         action_o,
  output logic [7:0]         out_port_o,
  output logic [47:0]        out_dst_mac_o,
  output logic [47:0]        out_src_mac_o,
  output logic [31:0]        reply_sender_ip_o,
  output logic [31:0]        reply_target_ip_o
);

  localparam int unsigned IdxW = arpnf_pkg::IDX_W;

  // config
  logic        if_valid_q;
  logic [7:0]  if_port_q;
  logic [31:0] if_ip_q;
  logic [47:0] if_mac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      if_valid_q <= 1'b0;
      if_port_q  <= '0;
      if_ip_q    <= '0;
      if_mac_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        arpnf_pkg::CFG_VALID: if_valid_q <= cfg_data_i[0];
        arpnf_pkg::CFG_PORT:  if_port_q  <= cfg_data_i[7:0];
        arpnf_pkg::CFG_IP:    if_ip_q    <= cfg_data_i[31:0];
        arpnf_pkg::CFG_MAC:   if_mac_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured header
  logic        is_arp_q;
  logic [7:0]  port_q;
  logic [47:0] smac_q;
  logic [15:0] opcode_q;
  logic [31:0] sip_q;
  logic [31:0] tip_q;
  logic [31:0] key_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      is_arp_q <= (in_op_i == arpnf_pkg::OP_ARP);
      port_q   <= in_port_i;
      smac_q   <= in_src_mac_i;
      opcode_q <= in_arp_opcode_i;
      sip_q    <= in_arp_sender_ip_i;
      tip_q    <= in_arp_target_ip_i;
      key_q    <= (in_op_i == arpnf_pkg::OP_ARP) ? in_arp_sender_ip_i : in_ip_dest_i;
    end
  end

  // probe address / count, clear sweep counter
  logic [IdxW-1:0] addr_q, probe_q, clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      probe_q <= '0;
      clr_q   <= '0;
    end else begin
      if (cmd_i.capture) begin
        addr_q  <= arpnf_pkg::hash_ip(
                     (in_op_i == arpnf_pkg::OP_ARP) ? in_arp_sender_ip_i : in_ip_dest_i);
        probe_q <= '0;
      end else if (cmd_i.probe_next) begin
        addr_q  <= addr_q + 1'b1;
        probe_q <= probe_q + 1'b1;
      end
      if (cmd_i.clear_step) clr_q <= clr_q + 1'b1;
    end
  end

  // neighbor table
  arpnf_pkg::entry_t rd_entry, wr_entry;
  logic [arpnf_pkg::ENTRY_W-1:0] rd_raw;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic            hit, empty, here;

  assign rd_entry = arpnf_pkg::entry_t'(rd_raw);
  assign hit      = rd_entry.valid && (rd_entry.ip == key_q);
  assign empty    = !rd_entry.valid;
  assign here     = if_valid_q && (port_q == if_port_q);

  always_comb begin
    wr_entry       = '0;
    wr_entry.valid = !cmd_i.clear_step;
    wr_entry.ip    = cmd_i.clear_step ? '0 : sip_q;
    wr_entry.mac   = cmd_i.clear_step ? '0 : smac_q;
    wr_entry.port  = cmd_i.clear_step ? '0 : port_q;
  end

  assign ram_we    = cmd_i.clear_step || (cmd_i.resolve && is_arp_q && empty);
  assign ram_waddr = cmd_i.clear_step ? clr_q : addr_q;

  arpnf_ram #(
    .Width(arpnf_pkg::ENTRY_W),
    .Depth(arpnf_pkg::NEIGHBOR_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_entry),
    .raddr_i(addr_q),
    .rdata_o(rd_raw)
  );

  // pending result; zero means drop
  logic [1:0]  res_act_q;
  logic [7:0]  res_port_q;
  logic [47:0] res_dmac_q, res_smac_q;
  logic [31:0] res_sip_q, res_tip_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_act_q  <= arpnf_pkg::ACT_DROP;
      res_port_q <= '0;
      res_dmac_q <= '0;
      res_smac_q <= '0;
      res_sip_q  <= '0;
      res_tip_q  <= '0;
    end else if (cmd_i.resolve) begin
      if (is_arp_q) begin
        if (here && opcode_q == arpnf_pkg::ARP_REQUEST && tip_q == if_ip_q) begin
          res_act_q  <= arpnf_pkg::ACT_REPLY;
          res_port_q <= port_q;
          res_dmac_q <= smac_q;
          res_smac_q <= if_mac_q;
          res_sip_q  <= tip_q;
          res_tip_q  <= sip_q;
        end
      end else if (here && hit) begin
        res_act_q  <= arpnf_pkg::ACT_FORWARD;
        res_port_q <= rd_entry.port;
        res_dmac_q <= rd_entry.mac;
        res_smac_q <= if_mac_q;
      end
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      action_o          <= res_act_q;
      out_port_o        <= res_port_q;
      out_dst_mac_o     <= res_dmac_q;
      out_src_mac_o     <= res_smac_q;
      reply_sender_ip_o <= res_sip_q;
      reply_target_ip_o <= res_tip_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.is_other   = (in_op_i != arpnf_pkg::OP_ARP) && (in_op_i != arpnf_pkg::OP_IPV4);
  assign status_o.hit        = hit;
  assign status_o.empty      = empty;
  assign status_o.last_probe = (probe_q == IdxW'(arpnf_pkg::NEIGHBOR_ENTRIES - 1));
  assign status_o.clr_last   = (clr_q == IdxW'(arpnf_pkg::NEIGHBOR_ENTRIES - 1));
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

// ===== hw/rtl/arp_responder_neighbor_forwarder.sv =====
// ----------------------------------------------------------------------------
// arp_responder_neighbor_forwarder
// Per-header ARP reply / IPv4 neighbor forward with a learned neighbor table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one parsed header word.
//   Output channel (out_valid_o / out_stall_i) gives one result word per
//   header, in order: drop, ARP reply or forward.
//   Neighbor table: 1024-entry hashed memory with linear probing, each
//   probe a registered RAM read, then a compare. ARP headers learn
//   their sender if absent and a free slot is found.
//   A header probes until a hit, a free slot or a full sweep of the table;
//   non-ARP/non-IPv4 headers skip the table.
//   One header in flight; a header holds the sequencer through idle, read,
//   compare and result load (another read and compare per extra probe), or
//   idle and result load for other ethertypes. The next header is taken
//   once the result sits in the output register, so a stalled receiver
//   holds one word while the next header is processed; after that the
//   input stalls.
//   Reset: a clearing sweep zeroes all 1024 table entries; input stalls
//   during it. Config writes are taken any time and belong in idle periods.
// ----------------------------------------------------------------------------
module arp_responder_neighbor_forwarder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  in_port_i,
  input  logic [47:0] src_mac_i,
  input  logic [15:0] arp_opcode_i,
  input  logic [31:0] arp_sender_ip_i,
  input  logic [31:0] arp_target_ip_i,
  input  logic [31:0] ip_dest_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [7:0]  out_port_o,
  output logic [47:0] out_dst_mac_o,
  output logic [47:0] out_src_mac_o,
  output logic [31:0] reply_sender_ip_o,
  output logic [31:0] reply_target_ip_o
);

  arpnf_pkg::cmd_t    cmd;
  arpnf_pkg::status_t status;

  // sequencer
  arpnf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .status_i  (status),
    .cmd_o     (cmd),
    .in_stall_o(in_stall_o)
  );

  // table, config and result datapath
  arpnf_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_op_i           (op_i),
    .in_port_i         (in_port_i),
    .in_src_mac_i      (src_mac_i),
    .in_arp_opcode_i   (arp_opcode_i),
    .in_arp_sender_ip_i(arp_sender_ip_i),
    .in_arp_target_ip_i(arp_target_ip_i),
    .in_ip_dest_i      (ip_dest_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .action_o          (action_o),
    .out_port_o        (out_port_o),
    .out_dst_mac_o     (out_dst_mac_o),
    .out_src_mac_o     (out_src_mac_o),
    .reply_sender_ip_o (reply_sender_ip_o),
    .reply_target_ip_o (reply_target_ip_o)
  );

endmodule
